>>> rtl/pics_pkg.sv
// ----------------------------------------------------------------------------
// pics_pkg
// Shared widths, command codes and controller/datapath bundles for the
// even-odd point-in-shape crossing counter.
// ----------------------------------------------------------------------------
package pics_pkg;

  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 24;

  // curve parameter t and weights: unsigned, FRAC_BITS fraction bits, t <= 1.0
  localparam int T_W    = FRAC_BITS + 1;
  // a = sy - 2cy + ey and b = 2cy - 2sy
  localparam int AB_W   = COORD_BITS + 2;
  // discriminant b^2 - 4ac, signed
  localparam int FAC_W  = 2 * COORD_BITS + 5;
  // square root result; its radicand takes 2*SQ_W bits
  localparam int SQ_W   = COORD_BITS + 2;
  localparam int SQR_W  = SQ_W + 2;
  // divider numerator/denominator, signed, and their magnitudes
  localparam int DIV_W  = COORD_BITS + 4;
  localparam int MAG_W  = COORD_BITS + 3;
  localparam int REM_W  = MAG_W + 1;
  // shared signed multiplier
  localparam int MUL_W  = (FRAC_BITS > COORD_BITS) ? FRAC_BITS + 2 : COORD_BITS + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;
  // step counter covers the divider and the square root loops
  localparam int CNT_LIM = (FRAC_BITS > SQ_W - 1) ? FRAC_BITS : SQ_W - 1;
  localparam int CNT_W   = $clog2(CNT_LIM + 1);

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  // datapath register operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_ACC_LD   = 4'd2;
  localparam logic [OP_W-1:0] OP_ACC_ADD  = 4'd3;
  localparam logic [OP_W-1:0] OP_ACC_SX   = 4'd4;
  localparam logic [OP_W-1:0] OP_FAC      = 4'd5;
  localparam logic [OP_W-1:0] OP_SQ_INIT  = 4'd6;
  localparam logic [OP_W-1:0] OP_SQ_STEP  = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd9;
  localparam logic [OP_W-1:0] OP_W0       = 4'd10;
  localparam logic [OP_W-1:0] OP_W1       = 4'd11;
  localparam logic [OP_W-1:0] OP_W2       = 4'd12;
  localparam logic [OP_W-1:0] OP_CMP      = 4'd13;
  localparam logic [OP_W-1:0] OP_HORIZ    = 4'd14;
  localparam logic [OP_W-1:0] OP_FIN      = 4'd15;

  // multiplier operand selects
  localparam int MS_W = 4;
  localparam logic [MS_W-1:0] MS_NONE = 4'd0;
  localparam logic [MS_W-1:0] MS_BB   = 4'd1;
  localparam logic [MS_W-1:0] MS_AC   = 4'd2;
  localparam logic [MS_W-1:0] MS_DTDT = 4'd3;
  localparam logic [MS_W-1:0] MS_DTT  = 4'd4;
  localparam logic [MS_W-1:0] MS_TT   = 4'd5;
  localparam logic [MS_W-1:0] MS_W0SX = 4'd6;
  localparam logic [MS_W-1:0] MS_W1CX = 4'd7;
  localparam logic [MS_W-1:0] MS_W2EX = 4'd8;
  localparam logic [MS_W-1:0] MS_DXT  = 4'd9;

  // divider operand selects
  localparam int DS_W = 2;
  localparam logic [DS_W-1:0] DS_STR = 2'd0;  // straight edge
  localparam logic [DS_W-1:0] DS_LIN = 2'd1;  // curve with a == 0
  localparam logic [DS_W-1:0] DS_RP  = 2'd2;  // root (-b + s) / 2a
  localparam logic [DS_W-1:0] DS_RM  = 2'd3;  // root (-b - s) / 2a

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [MS_W-1:0] msel;
    logic [DS_W-1:0] dsel;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic straight;
    logic off_y;
    logic horiz;
    logic a_zero;
    logic b_zero;
    logic fac_neg;
    logic t_ok;
    logic out_block;
  } dp_stat_t;

endpackage

>>> rtl/pics_ctrl.sv
// ----------------------------------------------------------------------------
// pics_ctrl
// Sequencer: walks one edge through decode, discriminant, square root,
// division and curve evaluation by issuing datapath commands.
// ----------------------------------------------------------------------------
module pics_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pics_pkg::dp_stat_t st,
  output pics_pkg::dp_cmd_t  cmd
);
  import pics_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_AC   = 5'd2;
  localparam logic [4:0] S_FAC  = 5'd3;
  localparam logic [4:0] S_SQI  = 5'd4;
  localparam logic [4:0] S_SQ   = 5'd5;
  localparam logic [4:0] S_DIVI = 5'd6;
  localparam logic [4:0] S_DIV  = 5'd7;
  localparam logic [4:0] S_TCHK = 5'd8;
  localparam logic [4:0] S_SL   = 5'd9;
  localparam logic [4:0] S_R1   = 5'd10;
  localparam logic [4:0] S_R2   = 5'd11;
  localparam logic [4:0] S_R3   = 5'd12;
  localparam logic [4:0] S_R4   = 5'd13;
  localparam logic [4:0] S_R5   = 5'd14;
  localparam logic [4:0] S_R6   = 5'd15;
  localparam logic [4:0] S_CMP  = 5'd16;
  localparam logic [4:0] S_NEXT = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;

  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DS_W-1:0]  dsel_r, dsel_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dsel_nxt  = dsel_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.msel  = MS_NONE;
    cmd.dsel  = dsel_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.skip) begin
          state_nxt = S_FIN;
        end else if (st.straight) begin
          if (st.off_y) begin
            state_nxt = S_FIN;
          end else if (st.horiz) begin
            cmd.op    = OP_HORIZ;
            state_nxt = S_FIN;
          end else begin
            dsel_nxt  = DS_STR;
            state_nxt = S_DIVI;
          end
        end else if (st.a_zero) begin
          if (st.b_zero) begin
            state_nxt = S_FIN;
          end else begin
            dsel_nxt  = DS_LIN;
            state_nxt = S_DIVI;
          end
        end else begin
          cmd.msel  = MS_BB;
          state_nxt = S_AC;
        end
      end
      S_AC: begin
        cmd.op    = OP_ACC_LD;
        cmd.msel  = MS_AC;
        state_nxt = S_FAC;
      end
      S_FAC: begin
        cmd.op    = OP_FAC;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        if (st.fac_neg) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SQ_INIT;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ_STEP;
        if (cnt_r == CNT_W'(SQ_W - 1)) begin
          dsel_nxt  = DS_RP;
          state_nxt = S_DIVI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          state_nxt = S_TCHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TCHK: begin
        if (!st.t_ok) begin
          state_nxt = S_NEXT;
        end else if (dsel_r == DS_STR) begin
          cmd.msel  = MS_DXT;
          state_nxt = S_SL;
        end else begin
          cmd.msel  = MS_DTDT;
          state_nxt = S_R1;
        end
      end
      S_SL: begin
        cmd.op    = OP_ACC_SX;
        state_nxt = S_CMP;
      end
      S_R1: begin
        cmd.op    = OP_W0;
        cmd.msel  = MS_DTT;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.op    = OP_W1;
        cmd.msel  = MS_TT;
        state_nxt = S_R3;
      end
      S_R3: begin
        cmd.op    = OP_W2;
        cmd.msel  = MS_W0SX;
        state_nxt = S_R4;
      end
      S_R4: begin
        cmd.op    = OP_ACC_LD;
        cmd.msel  = MS_W1CX;
        state_nxt = S_R5;
      end
      S_R5: begin
        cmd.op    = OP_ACC_ADD;
        cmd.msel  = MS_W2EX;
        state_nxt = S_R6;
      end
      S_R6: begin
        cmd.op    = OP_ACC_ADD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        // second root of a quadratic still to go
        if (dsel_r == DS_RP) begin
          dsel_nxt  = DS_RM;
          state_nxt = S_DIVI;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // on a last edge, hold while the previous result is still waiting
        if (!st.out_block) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dsel_r  <= DS_STR;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DEC))
    else $error("accepted transaction did not start decode");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_W'(FRAC_BITS)))
    else $error("divider step count overran");
  a_sq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (cnt_r <= CNT_W'(SQ_W - 1)))
    else $error("square root step count overran");
  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !st.out_block) |=> (state_r == S_IDLE))
    else $error("finish did not return to idle");
`endif

endmodule

>>> rtl/pics_dp.sv
// ----------------------------------------------------------------------------
// pics_dp
// Datapath: edge registers, shared multiplier, accumulator, bit-serial
// square root, restoring divider, crossing parity and result register.
// ----------------------------------------------------------------------------
module pics_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pics_pkg::dp_cmd_t                      cmd,
  output pics_pkg::dp_stat_t                     st,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_ctrl_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_ctrl_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_stop_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_stop_y,
  input  logic                                   in_is_straight,
  input  logic                                   in_last_edge,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_inside_res
);
  import pics_pkg::*;

  logic signed [COORD_BITS-1:0] px_r, py_r, sx_r, sy_r, cx_r, cy_r, ex_r, ey_r;
  logic                         straight_r, last_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [FAC_W-1:0]  fac_r;
  logic [T_W-1:0]           w0_r, w1_r, w2_r;

  logic [2*SQ_W-1:0] sq_v_r;
  logic [SQR_W-1:0]  sq_rem_r;
  logic [SQ_W-1:0]   root_r;

  logic [REM_W-1:0] rem_r;
  logic [MAG_W-1:0] dmag_r;
  logic [T_W-1:0]   q_r;
  logic             ovf_r, neg_r;

  logic parity_r, out_valid_r, out_inside_r;

  // edge coefficients
  logic signed [AB_W-1:0] a_v, b_v, c_v;
  assign a_v = AB_W'(sy_r) - (AB_W'(cy_r) <<< 1) + AB_W'(ey_r);
  assign b_v = (AB_W'(cy_r) <<< 1) - (AB_W'(sy_r) <<< 1);
  assign c_v = AB_W'(sy_r) - AB_W'(py_r);

  logic [T_W-1:0] dt_v;
  assign dt_v = T_ONE - q_r;

  // divider operands
  logic signed [DIV_W-1:0] num_v, den_v, num_neg, den_neg;
  logic [MAG_W-1:0]        nmag_v, dmag_v;
  always_comb begin
    case (cmd.dsel)
      DS_STR: begin
        num_v = DIV_W'(py_r) - DIV_W'(sy_r);
        den_v = DIV_W'(ey_r) - DIV_W'(sy_r);
      end
      DS_LIN: begin
        num_v = -DIV_W'(c_v);
        den_v = DIV_W'(b_v);
      end
      DS_RP: begin
        num_v = DIV_W'(root_r) - DIV_W'(b_v);
        den_v = DIV_W'(a_v) <<< 1;
      end
      default: begin
        num_v = -DIV_W'(b_v) - DIV_W'(root_r);
        den_v = DIV_W'(a_v) <<< 1;
      end
    endcase
    num_neg = -num_v;
    den_neg = -den_v;
    nmag_v  = num_v[DIV_W-1] ? num_neg[MAG_W-1:0] : num_v[MAG_W-1:0];
    dmag_v  = den_v[DIV_W-1] ? den_neg[MAG_W-1:0] : den_v[MAG_W-1:0];
  end

  // divider step
  logic             d_ge;
  logic [REM_W-1:0] d_sub;
  assign d_ge  = rem_r >= REM_W'(dmag_r);
  assign d_sub = d_ge ? rem_r - REM_W'(dmag_r) : rem_r;

  // square root step
  logic [SQR_W+1:0] s_rem2, s_trial, s_diff;
  logic             s_ge;
  assign s_rem2  = {sq_rem_r, sq_v_r[2*SQ_W-1 -: 2]};
  assign s_trial = (SQR_W+2)'({root_r, 2'b01});
  assign s_ge    = s_rem2 >= s_trial;
  assign s_diff  = s_rem2 - s_trial;

  // shared multiplier
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod_nxt;
  always_comb begin
    case (cmd.msel)
      MS_BB: begin
        ma = MUL_W'(b_v);
        mb = MUL_W'(b_v);
      end
      MS_AC: begin
        ma = MUL_W'(a_v);
        mb = MUL_W'(c_v);
      end
      MS_DTDT: begin
        ma = MUL_W'(dt_v);
        mb = MUL_W'(dt_v);
      end
      MS_DTT: begin
        ma = MUL_W'(dt_v);
        mb = MUL_W'(q_r);
      end
      MS_TT: begin
        ma = MUL_W'(q_r);
        mb = MUL_W'(q_r);
      end
      MS_W0SX: begin
        ma = MUL_W'(w0_r);
        mb = MUL_W'(sx_r);
      end
      MS_W1CX: begin
        ma = MUL_W'(w1_r);
        mb = MUL_W'(cx_r);
      end
      MS_W2EX: begin
        ma = MUL_W'(w2_r);
        mb = MUL_W'(ex_r);
      end
      MS_DXT: begin
        ma = MUL_W'(ex_r) - MUL_W'(sx_r);
        mb = MUL_W'(q_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_nxt = ma * mb;
  end

  logic reach_v, horiz_hit_v;
  logic signed [COORD_BITS-1:0] xmax_v;
  assign reach_v     = acc_r >= (ACC_W'(px_r) <<< FRAC_BITS);
  assign xmax_v      = (sx_r > ex_r) ? sx_r : ex_r;
  assign horiz_hit_v = xmax_v >= px_r;

  always_comb begin
    st.skip      = (py_r == ey_r) && (px_r < ex_r);
    st.straight  = straight_r;
    st.off_y     = (py_r < sy_r && py_r < ey_r) || (py_r > sy_r && py_r > ey_r);
    st.horiz     = sy_r == ey_r;
    st.a_zero    = a_v == '0;
    st.b_zero    = b_v == '0;
    st.fac_neg   = fac_r[FAC_W-1];
    st.t_ok      = !ovf_r && (q_r <= T_ONE) && !(q_r != '0 && neg_r);
    st.out_block = last_r && out_valid_r && !out_ready;
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      OP_LOAD: begin
        px_r       <= in_point_x;
        py_r       <= in_point_y;
        sx_r       <= in_start_x;
        sy_r       <= in_start_y;
        cx_r       <= in_ctrl_x;
        cy_r       <= in_ctrl_y;
        ex_r       <= in_stop_x;
        ey_r       <= in_stop_y;
        straight_r <= in_is_straight;
        last_r     <= in_last_edge;
      end
      OP_ACC_LD:  acc_r <= ACC_W'(prod_r);
      OP_ACC_ADD: acc_r <= acc_r + ACC_W'(prod_r);
      OP_ACC_SX:  acc_r <= (ACC_W'(sx_r) <<< FRAC_BITS) + ACC_W'(prod_r);
      OP_FAC:     fac_r <= FAC_W'(acc_r - (ACC_W'(prod_r) <<< 2));
      OP_SQ_INIT: begin
        sq_v_r   <= fac_r[2*SQ_W-1:0];
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      OP_SQ_STEP: begin
        sq_v_r   <= {sq_v_r[2*SQ_W-3:0], 2'b00};
        sq_rem_r <= s_ge ? s_diff[SQR_W-1:0] : s_rem2[SQR_W-1:0];
        root_r   <= {root_r[SQ_W-2:0], s_ge};
      end
      OP_DIV_INIT: begin
        rem_r  <= REM_W'(nmag_v);
        dmag_r <= dmag_v;
        q_r    <= '0;
        ovf_r  <= {1'b0, nmag_v} >= {dmag_v, 1'b0};
        neg_r  <= num_v[DIV_W-1] ^ den_v[DIV_W-1];
      end
      OP_DIV_STEP: begin
        rem_r <= {d_sub[REM_W-2:0], 1'b0};
        q_r   <= {q_r[T_W-2:0], d_ge};
      end
      OP_W0: w0_r <= prod_r[FRAC_BITS +: T_W];
      OP_W1: w1_r <= prod_r[FRAC_BITS-1 +: T_W];
      OP_W2: w2_r <= prod_r[FRAC_BITS +: T_W];
      default: begin
      end
    endcase
    if (cmd.op == OP_FIN && last_r) begin
      out_inside_r <= parity_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // post a new result, or drop the one taken this cycle
      if (cmd.op == OP_FIN && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CMP:   parity_r <= parity_r ^ reach_v;
        OP_HORIZ: parity_r <= parity_r ^ horiz_hit_v;
        OP_FIN: begin
          if (last_r) begin
            parity_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

`ifndef SYNTHESIS
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN && last_r) |=> (out_valid_r && !parity_r))
    else $error("last edge did not post a result and clear parity");
  a_parity_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_CMP && cmd.op != OP_HORIZ && cmd.op != OP_FIN) |=> $stable(parity_r))
    else $error("parity changed outside a crossing update");
  a_sq_zero_lsbs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SQ_INIT) |=> (root_r == '0))
    else $error("square root did not start from zero");
`endif

endmodule

>>> rtl/point_in_curved_shape_even_odd.sv
// ----------------------------------------------------------------------------
// point_in_curved_shape_even_odd
// Even-odd point-in-shape test: one path edge per transaction, one inside
// flag per path on the edge marked last.
// ----------------------------------------------------------------------------
// Throughput: one edge at a time; the next transaction is taken in the cycle
//   after the current edge finishes. The bit-serial square root (one bit a
//   cycle) and the restoring divider (one quotient bit a cycle) set the time.
// Reset (rst_n, synchronous, active low) clears the sequencer, parity and
//   result valid.
module point_in_curved_shape_even_odd (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_ctrl_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_ctrl_y,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_stop_x,
  input  logic signed [pics_pkg::COORD_BITS-1:0] in_stop_y,
  input  logic                                   in_is_straight,
  input  logic                                   in_last_edge,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_inside_res
);
  import pics_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  pics_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pics_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_ctrl_x      (in_ctrl_x),
    .in_ctrl_y      (in_ctrl_y),
    .in_stop_x      (in_stop_x),
    .in_stop_y      (in_stop_y),
    .in_is_straight (in_is_straight),
    .in_last_edge   (in_last_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

endmodule

>>> bench/point_in_curved_shape_even_odd_tb.sv
// ----------------------------------------------------------------------------
// point_in_curved_shape_even_odd_tb
// Drives path edges into the even-odd crossing counter and checks the inside
// flag of each path against a predictor that tracks crossing parity.
// ----------------------------------------------------------------------------
module point_in_curved_shape_even_odd_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pics_pkg::*;

  localparam int CW = COORD_BITS;
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  typedef logic signed [127:0] big_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0;
  logic signed [CW-1:0] in_start_x = '0, in_start_y = '0;
  logic signed [CW-1:0] in_ctrl_x = '0, in_ctrl_y = '0;
  logic signed [CW-1:0] in_stop_x = '0, in_stop_y = '0;
  logic in_is_straight = 1'b0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;

  point_in_curved_shape_even_odd i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic parity_q = 1'b0;
  logic inside_q[$];
  int n_err = 0;
  bit idle_en = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_off = 0;
  int rx_gap = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    n_err++;
  endtask

  // t = trunc(num * 2^F / den), in range when 0 <= t <= 1.0
  function automatic bit frac_t(input big_t num, input big_t den, output big_t t);
    big_t mn, md, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn <<< FRAC_BITS) / md;
    t = q;
    if (q > (big_t'(1) <<< FRAC_BITS)) return 0;
    if (q != 0 && neg) return 0;
    return 1;
  endfunction

  function automatic bit curve_x_ge(input big_t px, input big_t sx, input big_t cx,
                                    input big_t ex, input big_t t);
    big_t dt, w0, w1, w2, s;
    dt = (big_t'(1) <<< FRAC_BITS) - t;
    w0 = (dt * dt) >>> FRAC_BITS;
    w1 = (2 * dt * t) >>> FRAC_BITS;
    w2 = (t * t) >>> FRAC_BITS;
    s = w0 * sx + w1 * cx + w2 * ex;
    return s >= (px <<< FRAC_BITS);
  endfunction

  function automatic big_t floor_sqrt(input big_t v);
    big_t r, c;
    r = 0;
    for (int k = 37; k >= 0; k--) begin
      c = r | (big_t'(1) <<< k);
      if (v >= c * c) r = c;
    end
    return r;
  endfunction

  function automatic int edge_crossings(input big_t px, input big_t py, input big_t sx,
                                        input big_t sy, input big_t cx, input big_t cy,
                                        input big_t ex, input big_t ey, input bit straight);
    big_t lo, hi, t, a, b, c, disc, s;
    int n;
    n = 0;
    if (py == ey && px < ex) return 0;
    if (straight) begin
      lo = sy < ey ? sy : ey;
      hi = sy < ey ? ey : sy;
      if (py < lo || py > hi) return 0;
      if (sy == ey) return ((sx > ex ? sx : ex) >= px) ? 1 : 0;
      if (!frac_t(py - sy, ey - sy, t)) return 0;
      return ((sx <<< FRAC_BITS) + (ex - sx) * t >= (px <<< FRAC_BITS)) ? 1 : 0;
    end
    a = sy - 2 * cy + ey;
    b = 2 * cy - 2 * sy;
    c = sy - py;
    if (a == 0) begin
      if (b != 0 && frac_t(-c, b, t) && curve_x_ge(px, sx, cx, ex, t)) return 1;
      return 0;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) return 0;
    s = floor_sqrt(disc);
    if (frac_t(-b + s, 2 * a, t) && curve_x_ge(px, sx, cx, ex, t)) n++;
    if (frac_t(-b - s, 2 * a, t) && curve_x_ge(px, sx, cx, ex, t)) n++;
    return n;
  endfunction

  // drop valid for the length of the gap
  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_edge(input logic signed [CW-1:0] px, py, sx, sy, cx, cy, ex, ey,
                           input bit straight, input bit last);
    int hits;
    idle_gap();
    hits = edge_crossings(px, py, sx, sy, cx, cy, ex, ey, straight);
    in_valid <= 1'b1;
    in_point_x <= px; in_point_y <= py;
    in_start_x <= sx; in_start_y <= sy;
    in_ctrl_x <= cx; in_ctrl_y <= cy;
    in_stop_x <= ex; in_stop_y <= ey;
    in_is_straight <= straight;
    in_last_edge <= last;
    do @(posedge clk); while (!in_ready);
    parity_q = parity_q ^ hits[0];
    if (last) begin
      inside_q.push_back(parity_q);
      parity_q = 1'b0;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 400)) - CW'(200);
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return CW'($urandom_range(0, 40000)) - CW'(20000);
    endcase
  endfunction

  // receiver: long hold on request, otherwise random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_gap <= int'($urandom_range(0, 7));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (inside_q.size() == 0) report_mismatch("unexpected result transaction");
      else begin
        logic e;
        e = inside_q.pop_front();
        if (out_inside_res !== e)
          report_mismatch($sformatf("inside_res %b, expected %b", out_inside_res, e));
      end
    end
  end

  task automatic test_directed();
    // square of side 100, point inside and outside
    send_edge(50, 50, 0, 0, 0, 0, 100, 0, 1, 0);
    send_edge(50, 50, 100, 0, 0, 0, 100, 100, 1, 0);
    send_edge(50, 50, 100, 100, 0, 0, 0, 100, 1, 0);
    send_edge(50, 50, 0, 100, 0, 0, 0, 0, 1, 1);
    send_edge(150, 50, 0, 0, 0, 0, 100, 0, 1, 0);
    send_edge(150, 50, 100, 0, 0, 0, 100, 100, 1, 1);
    // stop vertex on ray, horizontal edge on ray
    send_edge(0, 10, -5, 0, 0, 0, 5, 10, 1, 1);
    send_edge(0, 10, -5, 10, 0, 0, 5, 10, 1, 0);
    send_edge(0, 10, 5, 10, 0, 0, -5, 10, 1, 1);
    // curve with a = 0, a = b = 0, negative discriminant, double root, skipped edge, two roots
    send_edge(0, 50, 10, 0, 10, 50, 10, 100, 0, 1);
    send_edge(0, 50, 10, 50, 20, 50, 30, 50, 0, 1);
    send_edge(0, 200, 10, 0, 20, 100, 30, 0, 0, 1);
    send_edge(0, 50, 10, 0, 20, 100, 30, 0, 0, 1);
    send_edge(0, 0, 10, 0, 20, 0, 30, 0, 0, 0);
    send_edge(0, 40, 10, 0, 20, 100, 30, 0, 0, 1);
    // field extremes
    send_edge(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0);
    send_edge(CMIN, 0, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 0, 0);
    send_edge(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 1, 1);
    send_edge(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 1, 1);
    send_edge(-1, -1, -1, -1, -1, -1, -1, -1, 0, 1);
    drain();
  endtask

  task automatic send_random_path();
    int n;
    logic signed [CW-1:0] px, py, sx, sy, fx, fy, cx, cy, ex, ey;
    n = $urandom_range(1, 6);
    px = rand_coord(); py = rand_coord();
    sx = rand_coord(); sy = rand_coord();
    fx = sx; fy = sy;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 && $urandom_range(0, 7) != 0) begin
        ex = fx; ey = fy;
      end else begin
        ex = rand_coord(); ey = $urandom_range(0, 5) == 0 ? py : rand_coord();
      end
      cx = rand_coord(); cy = rand_coord();
      send_edge(px, py, sx, sy, cx, cy, ex, ey, 1'($urandom_range(0, 1)), i == n - 1);
      sx = ex; sy = ey;
    end
  endtask

  task automatic test_random_paths();
    for (int k = 0; k < 360; k++) send_random_path();
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int k = 0; k < 12; k++) send_random_path();
    drain();
  endtask

  task automatic test_no_idling();
    idle_en = 1'b0;
    for (int k = 0; k < 60; k++) send_random_path();
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_paths();
    drain();
    test_backpressure();
    test_no_idling();
    if (n_err == 0) $display("PASS point_in_curved_shape_even_odd");
    else $display("FAIL point_in_curved_shape_even_odd");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL point_in_curved_shape_even_odd");
    $finish;
  end
endmodule

>>> filelist.f
rtl/pics_pkg.sv
rtl/pics_ctrl.sv
rtl/pics_dp.sv
rtl/point_in_curved_shape_even_odd.sv
bench/point_in_curved_shape_even_odd_tb.sv
